// ===== rtl/wbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// Sizes, register indexes, result codes and the structs passed between the
// register file, the matcher and the top level.
// ----------------------------------------------------------------------------
package wbps_pkg;

   // Search geometry
   localparam int MAX_PATTERN_BYTES = 32;
   localparam int OFFSET_BITS       = 32;
   localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int PIDX_BITS         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   // Register file layout
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 64;
   localparam int PATTERN_REGS     = 4;
   localparam int BYTES_PER_REG    = 8;
   localparam int LENGTH_REG_BITS  = 6;
   localparam int MATCH_OFFSET_BITS = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WILDCARD = 3'd5;

   // Result status codes
   localparam logic STATUS_FOUND  = 1'b0;
   localparam logic STATUS_ABSENT = 1'b1;

   // Pattern laid out by window age: entry i is compared with the byte that
   // arrived i transfers ago; care clears wildcard and unused entries.
   typedef struct packed {
      logic [MAX_PATTERN_BYTES-1:0][7:0] aligned;
      logic [MAX_PATTERN_BYTES-1:0]      care;
      logic [LEN_BITS-1:0]               len;
   } cfg_type;

   typedef struct packed {
      logic                         valid;
      logic                         status;
      logic [MATCH_OFFSET_BITS-1:0] match_offset;
   } res_type;

endpackage
`default_nettype wire

// ===== rtl/wbps_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_csr: configuration registers
// Holds pattern bytes, length and wildcard; presents the pattern aligned to
// window age with a care mask and the effective length.
// ----------------------------------------------------------------------------
module wbps_csr
   import wbps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                        cfg
);

   logic [MAX_PATTERN_BYTES-1:0][7:0] pattern_ff;
   logic [LENGTH_REG_BITS-1:0]        length_ff;
   logic [7:0]                        wildcard_ff;
   logic                              csr_write;
   logic [LEN_BITS-1:0]               eff_len;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Pattern bytes: each byte picks its own register and lane
   for (genvar p = 0; p < MAX_PATTERN_BYTES; p++) begin : g_pat
      localparam int REG_IDX  = p / BYTES_PER_REG;
      localparam int LANE_IDX = p % BYTES_PER_REG;
      if (REG_IDX < PATTERN_REGS) begin : g_wr
         always_ff @(posedge clock) begin
            if (reset) begin
               pattern_ff[p] <= 8'h00;
            end else if (csr_write && csr_index == CSR_INDEX_BITS'(REG_IDX)) begin
               pattern_ff[p] <= csr_data[8*LANE_IDX +: 8];
            end
         end
      end else begin : g_zero
         assign pattern_ff[p] = 8'h00;
      end
   end

   // Length and wildcard registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= LENGTH_REG_BITS'(1);
         wildcard_ff <= 8'h00;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LENGTH:   length_ff   <= csr_data[LENGTH_REG_BITS-1:0];
            CSR_WILDCARD: wildcard_ff <= csr_data[7:0];
            default:      ;
         endcase
      end
   end

   // Clamp length into 1..MAX_PATTERN_BYTES
   always_comb begin
      logic [LENGTH_REG_BITS:0] len_raw;
      len_raw = {1'b0, length_ff};
      if (length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (len_raw > (LENGTH_REG_BITS+1)'(MAX_PATTERN_BYTES)) begin
         eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         eff_len = LEN_BITS'(len_raw);
      end
   end

   // Reverse the in-use pattern so that age i meets pattern byte len-1-i
   always_comb begin
      logic [LEN_BITS-1:0] rev;
      cfg.len = eff_len;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         rev = eff_len - LEN_BITS'(i + 1);
         if (LEN_BITS'(i) < eff_len) begin
            cfg.aligned[i] = pattern_ff[rev[PIDX_BITS-1:0]];
            cfg.care[i]    = (pattern_ff[rev[PIDX_BITS-1:0]] != wildcard_ff);
         end else begin
            cfg.aligned[i] = 8'h00;
            cfg.care[i]    = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wbps_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_matcher: sliding window, region byte count and parallel compare
// Shifts the new byte into the window, compares the full window in one pass
// and forms at most one result for the byte.
// ----------------------------------------------------------------------------
module wbps_matcher
   import wbps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   input  wire cfg_type    cfg,
   output res_type         res
);

   logic [MAX_PATTERN_BYTES-1:0][7:0] window_ff;
   logic [MAX_PATTERN_BYTES-1:0][7:0] window_in;
   logic [OFFSET_BITS-1:0]            seen_ff;
   logic [OFFSET_BITS-1:0]            seen_in;
   logic                              reported_ff;
   logic [MAX_PATTERN_BYTES-1:0]      hit_vec;
   logic                              saturated;
   logic                              found;
   logic [OFFSET_BITS-1:0]            offset_full;
   logic [63:0]                       offset_wide;

   // Shift the window by one byte
   always_comb begin
      window_in[0] = data_byte;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // Compare every window age against its aligned pattern byte
   always_comb begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         hit_vec[i] = !cfg.care[i] || (window_in[i] == cfg.aligned[i]);
      end
   end

   // Saturating region count and match decision
   assign saturated   = &seen_ff;
   assign seen_in     = saturated ? seen_ff : seen_ff + 1'b1;
   assign found       = !reported_ff && !saturated &&
                        (seen_in >= OFFSET_BITS'(cfg.len)) && (&hit_vec);
   assign offset_full = seen_in - OFFSET_BITS'(cfg.len);
   assign offset_wide = 64'(offset_full);

   // Result: found wins; not-found only on a region end without a match
   always_comb begin
      res.valid        = found || (last_byte && !reported_ff);
      res.status       = found ? STATUS_FOUND : STATUS_ABSENT;
      res.match_offset = found ? offset_wide[MATCH_OFFSET_BITS-1:0] : '0;
   end

   // Window data holds between transfers
   always_ff @(posedge clock) begin
      if (fire) begin
         window_ff <= window_in;
      end
   end

   // Region state: restart on the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (fire) begin
         if (last_byte) begin
            seen_ff     <= '0;
            reported_ff <= 1'b0;
         end else begin
            seen_ff <= seen_in;
            if (found) begin
               reported_ff <= 1'b1;
            end
         end
      end
   end

   a_notfound_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && res.valid && (res.status == STATUS_ABSENT) |-> last_byte)
      else $error("not-found result on a byte that does not end the region");

   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte |=> (seen_ff == '0) && !reported_ff)
      else $error("region state not cleared after the last byte");

   a_reported_has_bytes: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> (seen_ff != '0))
      else $error("match flagged in a region with no bytes");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      fire && reported_ff |-> !found)
      else $error("second match reported in one region");

endmodule
`default_nettype wire

// ===== rtl/wildcard_byte_pattern_search_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit: streaming byte signature scanner
// Scans a region byte by byte for a pattern with wildcard bytes and reports
// the offset of the first match, or not-found at the end of the region.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/stall     req_data_byte, req_last_byte
//  rsp      out        rsp_valid/stall     rsp_status, rsp_match_offset
//  csr      in         csr_valid/ready     csr_index, csr_data
//
//  One byte per cycle sustained while the output is not stalled; a byte
//  transfers into the input register, then a one-pass compare of the whole
//  32-byte window writes its result into the output register.
//  Synchronous reset clears control state and the configuration registers.
//  rsp_stall backs up into req_stall in the same cycle, only while the
//  input register holds a byte that cannot move on.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_unit
   import wbps_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_last_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_status,
   output logic [MATCH_OFFSET_BITS-1:0]      rsp_match_offset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_data
);

   cfg_type                      cfg;
   res_type                      res;
   logic                         stage_valid_ff;
   logic                         stage_valid_in;
   logic [7:0]                   stage_data_ff;
   logic                         stage_last_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_status_ff;
   logic [MATCH_OFFSET_BITS-1:0] rsp_offset_ff;
   logic                         out_free;
   logic                         fire;
   logic                         req_accept;

   wbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wbps_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (stage_data_ff),
      .last_byte (stage_last_ff),
      .cfg       (cfg),
      .res       (res)
   );

   // Flow control between input register and output register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = stage_valid_ff && out_free;
   assign req_stall  = stage_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign stage_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = (fire && res.valid) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_data_ff <= req_data_byte;
         stage_last_ff <= req_last_byte;
      end
   end

   // Capture a result; hold it while stalled
   always_ff @(posedge clock) begin
      if (fire && res.valid) begin
         rsp_status_ff <= res.status;
         rsp_offset_ff <= res.match_offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule
`default_nettype wire

// ===== bench/search_result_checker.sv =====
// ----------------------------------------------------------------------------
// search_result_checker: result predictor and comparator for the pattern scan
// Watches the byte, result and register channels of the scanner, keeps its
// own copy of the pattern settings and the sliding window, and compares every
// result transfer against the oldest predicted search result.
// ----------------------------------------------------------------------------
module search_result_checker
   import wbps_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_last_byte,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic                         rsp_status,
   input  wire logic [MATCH_OFFSET_BITS-1:0] rsp_match_offset,
   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                byte_count,
   output int                                region_count,
   output int                                found_count,
   output int                                missing_count,
   output int                                write_count
);

   // Mirrored settings
   logic [7:0]                 pattern_bytes [MAX_PATTERN_BYTES];
   logic [LENGTH_REG_BITS-1:0] length_setting;
   logic [7:0]                 wildcard_setting;

   // Mirrored search state of the current region
   logic [7:0]             recent_bytes [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] region_bytes;
   logic                   region_hit;

   res_type awaited_results [$];

   // Restart the search state for a new region
   task automatic clear_region();
      int i;
      for (i = 0; i < MAX_PATTERN_BYTES; i++) recent_bytes[i] = 8'h00;
      region_bytes = '0;
      region_hit   = 1'b0;
   endtask

   // Apply one register transfer to the mirrored settings
   task automatic apply_write(input logic [CSR_INDEX_BITS-1:0] index,
                              input logic [CSR_DATA_BITS-1:0] word);
      int b;
      if (index < PATTERN_REGS) begin
         for (b = 0; b < BYTES_PER_REG; b++) begin
            if (index * BYTES_PER_REG + b < MAX_PATTERN_BYTES)
               pattern_bytes[index * BYTES_PER_REG + b] = word[8*b +: 8];
         end
      end else if (index == CSR_LENGTH) begin
         length_setting = word[LENGTH_REG_BITS-1:0];
      end else if (index == CSR_WILDCARD) begin
         wildcard_setting = word[7:0];
      end
   endtask

   // Shift one byte into the window and queue the search result it causes
   task automatic scan_byte(input logic [7:0] data, input logic last);
      int unsigned span;
      int          i;
      logic        saturated;
      logic        hit;
      res_type     r;
      if (length_setting == 0)
         span = 1;
      else if (length_setting > MAX_PATTERN_BYTES)
         span = MAX_PATTERN_BYTES;
      else
         span = length_setting;
      saturated = (region_bytes == '1);
      for (i = MAX_PATTERN_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = data;
      if (!saturated) region_bytes = region_bytes + 1'b1;

      // compare the newest span bytes, oldest against pattern byte 0
      if (!region_hit && !saturated && region_bytes >= span) begin
         hit = 1'b1;
         for (i = 0; i < span; i++) begin
            if (pattern_bytes[i] != wildcard_setting &&
                pattern_bytes[i] != recent_bytes[span - 1 - i])
               hit = 1'b0;
         end
         if (hit) begin
            r.valid        = 1'b1;
            r.status       = STATUS_FOUND;
            r.match_offset = MATCH_OFFSET_BITS'(region_bytes - span);
            awaited_results.push_back(r);
            region_hit = 1'b1;
            found_count++;
         end
      end

      // end of region: report not-found unless a match was given
      if (last) begin
         if (!region_hit) begin
            r.valid        = 1'b1;
            r.status       = STATUS_ABSENT;
            r.match_offset = '0;
            awaited_results.push_back(r);
            missing_count++;
         end
         region_count++;
         clear_region();
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < MAX_PATTERN_BYTES; i++) pattern_bytes[i] = 8'h00;
         length_setting   = LENGTH_REG_BITS'(1);
         wildcard_setting = 8'h00;
         clear_region();
         awaited_results.delete();
         fail_count    = 0;
         byte_count    = 0;
         region_count  = 0;
         found_count   = 0;
         missing_count = 0;
         write_count   = 0;
      end else begin
         // compare a result transfer with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual status %0b offset %0d",
                        $time, rsp_status, rsp_match_offset);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0b, actual %0b",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_match_offset !== want.match_offset) begin
                  $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                           $time, want.match_offset, rsp_match_offset);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
            write_count++;
         end
         if (req_valid && !req_stall) begin
            scan_byte(req_data_byte, req_last_byte);
            byte_count++;
         end
      end
      pending = awaited_results.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the wildcard byte pattern search unit
// Drives regions of bytes and register settings into the scanner, with a
// directed opening and a long random run of embedded, broken and noise
// regions under random idling on both channels; the checker beside the block
// predicts and compares every search result.
// ----------------------------------------------------------------------------
module testbench;
   import wbps_pkg::*;

   localparam int ITEM_TARGET    = 1950;
   localparam int QUIET_FROM     = 1750;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 240;
   localparam int PRESSURE_ITEMS = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REG_COUNT      = 1 << CSR_INDEX_BITS;

   typedef enum logic [1:0] {
      REGION_EMBED,
      REGION_BROKEN,
      REGION_NOISE
   } region_kind_type;

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic [7:0]                   req_data_byte = 8'h00;
   logic                         req_last_byte = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic                         rsp_status;
   logic [MATCH_OFFSET_BITS-1:0] rsp_match_offset;
   logic                         csr_valid     = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data      = '0;

   int fail_count;
   int pending;
   int byte_count;
   int region_count;
   int found_count;
   int missing_count;
   int write_count;

   // Settings as written to the block, used to shape the stimulus
   logic [7:0]                 pat_img [MAX_PATTERN_BYTES];
   logic [LENGTH_REG_BITS-1:0] len_img;
   logic [7:0]                 wild_img;

   int   items_sent  = 0;
   int   idle_cycles = 0;
   logic hold_output = 1'b0;
   logic steady_run  = 1'b0;

   always #6 clock = ~clock;

   wildcard_byte_pattern_search_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   search_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .byte_count       (byte_count),
      .region_count     (region_count),
      .found_count      (found_count),
      .missing_count    (missing_count),
      .write_count      (write_count)
   );

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin : result_side
      int burst;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall   <= 1'b0;
            hold_output = 1'b0;
         end else if (!steady_run && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int unsigned span();
      if (len_img == 0) return 1;
      if (len_img > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
      return len_img;
   endfunction

   // Offer one byte, with an occasional gap first, and hold until transfer
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      if (!steady_run && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Wait until every predicted result has arrived, then let the block settle
   task automatic drain();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] word);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write the registers selected by mask from the settings image
   task automatic program_regs(input logic [REG_COUNT-1:0] mask);
      logic [CSR_DATA_BITS-1:0] word;
      int idx, b;
      for (idx = 0; idx < REG_COUNT; idx++) begin
         if (mask[idx]) begin
            word = {$urandom, $urandom};
            if (idx < PATTERN_REGS) begin
               for (b = 0; b < BYTES_PER_REG; b++)
                  word[8*b +: 8] = pat_img[idx * BYTES_PER_REG + b];
            end else if (idx == CSR_LENGTH) begin
               word[LENGTH_REG_BITS-1:0] = len_img;
            end else if (idx == CSR_WILDCARD) begin
               word[7:0] = wild_img;
            end
            write_reg(CSR_INDEX_BITS'(idx), word);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Draw new values for a random subset of the registers
   task automatic draw_settings(output logic [REG_COUNT-1:0] mask);
      int k, b, pick;
      mask = '0;
      if ($urandom_range(0, 3) != 0) begin
         mask[CSR_WILDCARD] = 1'b1;
         if ($urandom_range(0, 3) == 0)
            wild_img = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else
            wild_img = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 3) != 0) begin
         mask[CSR_LENGTH] = 1'b1;
         pick = $urandom_range(0, 7);
         case (pick)
            0: len_img = '0;
            1: len_img = LENGTH_REG_BITS'(MAX_PATTERN_BYTES);
            2: len_img = LENGTH_REG_BITS'($urandom_range(MAX_PATTERN_BYTES + 1, 63));
            3: len_img = LENGTH_REG_BITS'(1);
            default: len_img = LENGTH_REG_BITS'($urandom_range(1, MAX_PATTERN_BYTES));
         endcase
      end
      for (k = 0; k < PATTERN_REGS; k++) begin
         if ($urandom_range(0, 3) != 0) begin
            mask[k] = 1'b1;
            for (b = 0; b < BYTES_PER_REG; b++) begin
               if ($urandom_range(0, 3) == 0)
                  pat_img[k * BYTES_PER_REG + b] = wild_img;
               else
                  pat_img[k * BYTES_PER_REG + b] = 8'($urandom_range(0, 255));
            end
         end
      end
      // now and then touch an index that holds no register
      if ($urandom_range(0, 9) == 0)
         mask[$urandom_range(CSR_WILDCARD + 1, REG_COUNT - 1)] = 1'b1;
   endtask

   // Send one region, optionally carrying the pattern or a near miss of it
   task automatic send_region(input int unsigned size, input region_kind_type kind);
      int unsigned n, pos, flip, i;
      logic [7:0]  data;
      n    = span();
      pos  = (size >= n) ? $urandom_range(0, size - n) : 0;
      flip = $urandom_range(0, n - 1);
      for (i = 0; i < size; i++) begin
         if (kind != REGION_NOISE && size >= n && i >= pos && i < pos + n) begin
            data = pat_img[i - pos];
            if (data == wild_img)
               data = 8'($urandom_range(0, 255));
            else if (kind == REGION_BROKEN && i - pos == flip)
               data = ~data;
         end else if ($urandom_range(0, 1) == 0) begin
            data = pat_img[$urandom_range(0, n - 1)];
         end else begin
            data = 8'($urandom_range(0, 255));
         end
         send_byte(data, i == size - 1);
      end
   endtask

   initial begin : stimulus
      logic [REG_COUNT-1:0] mask;
      int                   phase, quota, i, pick;
      int unsigned          size;
      region_kind_type      kind;

      for (i = 0; i < MAX_PATTERN_BYTES; i++) pat_img[i] = 8'h00;
      len_img  = LENGTH_REG_BITS'(1);
      wild_img = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: pattern byte 0 equals the wildcard, so any byte hits;
      // the byte after the hit is dropped and its last flag restarts the search
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      req_valid <= 1'b0;
      drain();

      // four-byte pattern with a wildcard in the third place
      pat_img[0] = 8'hDE;
      pat_img[1] = 8'hAD;
      pat_img[2] = 8'h3C;
      pat_img[3] = 8'hEF;
      len_img    = LENGTH_REG_BITS'(4);
      wild_img   = 8'h3C;
      program_regs('1);
      send_byte(8'h11, 1'b0);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'h22, 1'b1);
      // match completing on the last byte gives only the found result
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hEF, 1'b1);
      // region shorter than the pattern
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b1);
      req_valid <= 1'b0;
      drain();

      // zero length acts as a one-byte pattern
      len_img = '0;
      mask    = '0;
      mask[CSR_LENGTH] = 1'b1;
      program_regs(mask);
      send_byte(8'h00, 1'b0);
      send_byte(8'hDE, 1'b1);
      req_valid <= 1'b0;
      drain();

      // overlong length is clipped to the full window
      len_img = '1;
      program_regs(mask);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      req_valid <= 1'b0;
      drain();

      // pattern rewritten in the middle of a region
      len_img    = LENGTH_REG_BITS'(2);
      pat_img[0] = 8'hAA;
      pat_img[1] = 8'hBB;
      mask       = '0;
      mask[CSR_LENGTH] = 1'b1;
      mask[0]          = 1'b1;
      program_regs(mask);
      send_byte(8'hAA, 1'b0);
      req_valid <= 1'b0;
      drain();
      pat_img[1] = 8'hCC;
      mask       = '0;
      mask[0]    = 1'b1;
      program_regs(mask);
      send_byte(8'hCC, 1'b1);
      req_valid <= 1'b0;

      // random phases of settings and regions
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         draw_settings(mask);
         program_regs(mask);

         // fill the block while the result side holds off
         if (phase == 2) begin
            hold_output = 1'b1;
            for (i = 0; i < PRESSURE_ITEMS; i++)
               send_byte(8'($urandom_range(0, 255)), 1'b1);
         end

         quota = items_sent + $urandom_range(60, 160);
         while (items_sent < quota && items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? REGION_EMBED : (pick < 8) ? REGION_BROKEN : REGION_NOISE;
            if ($urandom_range(0, 7) == 0)
               size = $urandom_range(1, 100);
            else
               size = $urandom_range(1, span() + 12);
            send_region(size, kind);
            // pause the sender until all results are back
            if ($urandom_range(0, 24) == 0) begin
               req_valid <= 1'b0;
               drain();
            end
            if (items_sent >= QUIET_FROM) steady_run = 1'b1;
         end
         req_valid <= 1'b0;
         phase++;
      end

      drain();
      $display("Scanned %0d bytes in %0d regions across %0d register writes",
               byte_count, region_count, write_count);
      $display("Search results: %0d found, %0d not found", found_count, missing_count);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
